[design/fccw_pkg.sv]
// Package for the FAT12 cluster chain walker.
// Holds the request and register codes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package fccw_pkg;

    localparam int ClusterWidth = 12;
    localparam int LbaWidth     = 20;
    localparam int PosWidth     = 13;

    // Request type codes.
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_START   = 2'd1;
    localparam logic [1:0] REQ_ADVANCE = 2'd2;

    // Configuration register indexes.
    localparam logic REG_DATA_START = 1'b0;
    localparam logic REG_SPC        = 1'b1;

    localparam logic [ClusterWidth-1:0] END_OF_CHAIN = 12'hFF8;
    localparam logic [7:0]              BYTE_BEYOND  = 8'hFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;       // load transaction: write one FAT byte
        logic take_first;  // start transaction: load first_cluster
        logic rd_hi;       // second FAT read, capture low byte and address
        logic finish;      // combine bytes and emit the result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic active;
    } status_t;

endpackage

`default_nettype wire

[design/fccw_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module fccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/fccw_ctrl.sv]
// Controller of the FAT12 cluster chain walker: accepts transactions and
// sequences the two FAT reads and the result. Depends on fccw_pkg.
`default_nettype none

module fccw_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [1:0]       req_type,
    input  wire fccw_pkg::status_t status,
    output logic                  busy,
    output fccw_pkg::cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RDHI = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   walk;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    // An advance with no chain in progress is dropped without a result.
    assign walk   = accept && ((req_type == fccw_pkg::REQ_START) ||
                               ((req_type == fccw_pkg::REQ_ADVANCE) && status.active));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (walk)
                begin
                    state_next = ST_RDHI;
                end
            end
            ST_RDHI: state_next = ST_FIN;
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd.write      = accept && (req_type == fccw_pkg::REQ_LOAD);
        cmd.take_first = accept && (req_type == fccw_pkg::REQ_START);
        cmd.rd_hi      = (state_reg == ST_RDHI);
        cmd.finish     = (state_reg == ST_FIN);
    end

endmodule

`default_nettype wire

[design/fccw_datapath.sv]
// Datapath of the FAT12 cluster chain walker: configuration registers,
// FAT store, cluster state, address arithmetic and result registers.
// Depends on fccw_pkg and fccw_ram.
`default_nettype none

module fccw_datapath #(
    parameter int FAT_BYTES = 8192
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fccw_pkg::cmd_t    cmd,
    output fccw_pkg::status_t      status,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic [12:0]       fat_index,
    input  wire logic [7:0]        fat_byte,
    input  wire logic [11:0]       first_cluster,
    output logic                   result_strobe,
    output logic [19:0]            sector_lba,
    output logic [7:0]             sector_count,
    output logic [11:0]            cluster_number,
    output logic                   last_cluster,
    output logic                   bad_cluster
);

    localparam int          AddrWidth = $clog2(FAT_BYTES);
    localparam logic [13:0] FatLimit  = 14'(FAT_BYTES);

    logic [15:0] data_start_reg;
    logic [7:0]  spc_reg;
    logic [11:0] cluster_reg;
    logic        active_reg;
    logic [7:0]  byte_lo_reg;
    logic [19:0] lba_reg;

    logic        strobe_reg;
    logic [19:0] sector_lba_reg;
    logic [7:0]  sector_count_reg;
    logic [11:0] cluster_number_reg;
    logic        last_reg;
    logic        bad_reg;

    logic [11:0]          c_sel;
    logic [12:0]          pos_sel;
    logic [12:0]          pos_cur;
    logic [12:0]          pos_cur_hi;
    logic                 lo_oob;
    logic                 hi_oob;
    logic                 index_ok;
    logic                 ram_we;
    logic [AddrWidth-1:0] ram_addr;
    logic [7:0]           ram_rdata;
    logic [7:0]           byte_hi;
    logic [15:0]          word;
    logic [11:0]          next_cluster;
    logic                 is_bad;
    logic                 is_end;
    logic [11:0]          cdiff;
    logic [19:0]          product;

    // Byte position of an entry is cluster * 3 / 2.
    assign c_sel      = cmd.take_first ? first_cluster : cluster_reg;
    assign pos_sel    = {1'b0, c_sel} + {2'b00, c_sel[11:1]};
    assign pos_cur    = {1'b0, cluster_reg} + {2'b00, cluster_reg[11:1]};
    assign pos_cur_hi = pos_cur + 13'd1;
    assign lo_oob     = ({1'b0, pos_cur} >= FatLimit);
    assign hi_oob     = ({1'b0, pos_cur_hi} >= FatLimit);
    assign index_ok   = ({1'b0, fat_index} < FatLimit);

    assign ram_we = cmd.write && index_ok;

    always_comb
    begin
        priority if (cmd.write)
        begin
            ram_addr = fat_index[AddrWidth-1:0];
        end
        else if (cmd.rd_hi)
        begin
            ram_addr = pos_cur_hi[AddrWidth-1:0];
        end
        else
        begin
            ram_addr = pos_sel[AddrWidth-1:0];
        end
    end

    fccw_ram #(
        .WIDTH (8),
        .DEPTH (FAT_BYTES)
    ) u_fat_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (fat_byte),
        .rdata (ram_rdata)
    );

    // Bytes past the end of the store read as 0xFF, so an entry lying wholly past the end ends the chain.
    assign byte_hi      = hi_oob ? fccw_pkg::BYTE_BEYOND : ram_rdata;
    assign word         = {byte_hi, byte_lo_reg};
    assign next_cluster = cluster_reg[0] ? word[15:4] : word[11:0];
    assign is_bad       = (cluster_reg[11:1] == 11'd0);
    assign is_end       = (next_cluster >= fccw_pkg::END_OF_CHAIN);

    assign cdiff   = cluster_reg - 12'd2;
    assign product = 20'(cdiff) * 20'(spc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_start_reg <= 16'd0;
            spc_reg        <= 8'd1;
            cluster_reg    <= 12'd0;
            active_reg     <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == fccw_pkg::REG_DATA_START))
            begin
                data_start_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == fccw_pkg::REG_SPC))
            begin
                spc_reg <= cfg_data[7:0];
            end

            if (cmd.take_first)
            begin
                cluster_reg <= first_cluster;
                active_reg  <= 1'b1;
            end
            else if (cmd.finish)
            begin
                if (!is_bad && !is_end)
                begin
                    cluster_reg <= next_cluster;
                end
                active_reg <= !is_bad && !is_end;
            end

            strobe_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_hi)
        begin
            byte_lo_reg <= lo_oob ? fccw_pkg::BYTE_BEYOND : ram_rdata;
            lba_reg     <= product + {4'd0, data_start_reg};
        end
        if (cmd.finish)
        begin
            sector_lba_reg     <= is_bad ? 20'd0 : lba_reg;
            sector_count_reg   <= spc_reg;
            cluster_number_reg <= cluster_reg;
            last_reg           <= !is_bad && is_end;
            bad_reg            <= is_bad;
        end
    end

    assign status.active  = active_reg;
    assign result_strobe  = strobe_reg;
    assign sector_lba     = sector_lba_reg;
    assign sector_count   = sector_count_reg;
    assign cluster_number = cluster_number_reg;
    assign last_cluster   = last_reg;
    assign bad_cluster    = bad_reg;

endmodule

`default_nettype wire

[design/fat12_cluster_chain_walker_unit.sv]
// Top level of the FAT12 cluster chain walker: controller plus datapath.
// Depends on fccw_pkg, fccw_ctrl, fccw_datapath and fccw_ram.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   request  | start, busy               | req_type, fat_index, fat_byte, first_cluster
//   result   | result_strobe (one cycle) | sector_lba, sector_count, cluster_number,
//            |                           | last_cluster, bad_cluster
//   config   | cfg_we                    | cfg_index, cfg_data
//
// A load transaction leaves busy low. A start, or an advance while a chain is
// active, raises busy after acceptance through the RDHI and FIN states, set by
// the two FAT byte reads through the single port of the store, and the result
// strobe comes in the cycle after FIN, in which a new request can already be taken.
// Reset clears the control state and sets the configuration to its defaults; the FAT store is not
// cleared and holds unknown data until loaded. The result side cannot stall.
`default_nettype none

module fat12_cluster_chain_walker_unit #(
    parameter int FAT_BYTES = 8192
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  req_type,
    input  wire logic [12:0] fat_index,
    input  wire logic [7:0]  fat_byte,
    input  wire logic [11:0] first_cluster,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             result_strobe,
    output logic [19:0]      sector_lba,
    output logic [7:0]       sector_count,
    output logic [11:0]      cluster_number,
    output logic             last_cluster,
    output logic             bad_cluster
);

    fccw_pkg::cmd_t    cmd;
    fccw_pkg::status_t status;

    fccw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .busy     (busy),
        .cmd      (cmd)
    );

    fccw_datapath #(
        .FAT_BYTES (FAT_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fat_index      (fat_index),
        .fat_byte       (fat_byte),
        .first_cluster  (first_cluster),
        .result_strobe  (result_strobe),
        .sector_lba     (sector_lba),
        .sector_count   (sector_count),
        .cluster_number (cluster_number),
        .last_cluster   (last_cluster),
        .bad_cluster    (bad_cluster)
    );

    // A result only follows a busy cycle.
    a_strobe_after_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy)
    ) else $error("result strobe without a preceding busy cycle");

    // A walk keeps busy high through the RDHI and FIN states.
    a_busy_length: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(busy) |=> busy ##1 !busy
    ) else $error("busy period is not two cycles");

    // Every accepted start transaction yields a result.
    a_start_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == fccw_pkg::REQ_START)) |-> ##3 result_strobe
    ) else $error("start transaction gave no result");

    // A flagged cluster reports address zero and never marks a chain end.
    a_bad_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_strobe && bad_cluster) |-> ((sector_lba == 20'd0) && !last_cluster)
    ) else $error("bad cluster result has address or end flag set");

endmodule

`default_nettype wire

[tb/sv/tb_fat12_cluster_chain_walker_unit.sv]
// Self-checking testbench for fat12_cluster_chain_walker_unit.
// Builds FAT12 chains in the store, walks them and checks every sector result.
// Depends on fccw_pkg and the walker RTL only.
`timescale 1ns / 100ps

module tb_fat12_cluster_chain_walker_unit;

    localparam int FAT_SIZE = 8192;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int ITEMS_PER_PHASE = 292;
    localparam int NUM_PHASES = 6;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [12:0] idx;
        logic [7:0]  byt;
        logic [11:0] first;
        logic        has_sector;
        logic [19:0] lba;
        logic [7:0]  cnt;
        logic [11:0] clus;
        logic        last;
        logic        bad;
    } request_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  req_type = fccw_pkg::REQ_LOAD;
    logic [12:0] fat_index = '0;
    logic [7:0]  fat_byte = '0;
    logic [11:0] first_cluster = '0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = fccw_pkg::REG_DATA_START;
    logic [15:0] cfg_data = '0;
    logic        result_strobe;
    logic [19:0] sector_lba;
    logic [7:0]  sector_count;
    logic [11:0] cluster_number;
    logic        last_cluster;
    logic        bad_cluster;

    // Shadow of the walker: FAT bytes, which of them were loaded, chain state and registers.
    logic [7:0]  fat_shadow [FAT_SIZE];
    bit          fat_known [FAT_SIZE];
    logic [11:0] walk_cluster = '0;
    bit          walk_active = 1'b0;
    logic [15:0] lba_base = '0;
    logic [7:0]  spc_reg = 8'd1;

    request_t    pending_reqs [$];
    request_t    expected_sectors [$];
    request_t    driven_req;
    int          requests_made = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          idle_pct = 0;
    bit          req_taken = 1'b0;
    bit          send;

    fat12_cluster_chain_walker_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .fat_index     (fat_index),
        .fat_byte      (fat_byte),
        .first_cluster (first_cluster),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .sector_lba    (sector_lba),
        .sector_count  (sector_count),
        .cluster_number(cluster_number),
        .last_cluster  (last_cluster),
        .bad_cluster   (bad_cluster)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Applies one request to the shadow and fills in the sector result it causes.
    task automatic walk_step(inout request_t r);
        int c;
        int pos;
        logic [15:0] word;
        logic [11:0] nxt;
        int addr;
        r.has_sector = 1'b0;
        r.lba = '0;
        r.cnt = '0;
        r.clus = '0;
        r.last = 1'b0;
        r.bad = 1'b0;
        if (r.kind == fccw_pkg::REQ_LOAD)
        begin
            fat_shadow[r.idx] = r.byt;
            fat_known[r.idx] = 1'b1;
        end
        if (r.kind == fccw_pkg::REQ_START)
        begin
            walk_cluster = r.first;
            walk_active = 1'b1;
        end
        if (r.kind == fccw_pkg::REQ_START || (r.kind == fccw_pkg::REQ_ADVANCE && walk_active))
        begin
            c = walk_cluster;
            r.has_sector = 1'b1;
            r.cnt = spc_reg;
            r.clus = walk_cluster;
            if (c < 2)
            begin
                r.bad = 1'b1;
                walk_active = 1'b0;
            end
            else
            begin
                addr = int'(lba_base) + (c - 2) * int'(spc_reg);
                r.lba = addr[19:0];
                pos = c * 3 / 2;
                word = {fat_shadow[pos + 1], fat_shadow[pos]};
                nxt = (c % 2 == 1) ? word[15:4] : word[11:0];
                if (nxt >= fccw_pkg::END_OF_CHAIN)
                begin
                    r.last = 1'b1;
                    walk_active = 1'b0;
                end
                else
                begin
                    walk_cluster = nxt;
                    walk_active = 1'b1;
                end
            end
        end
    endtask

    task automatic queue_request(input logic [1:0] kind, input logic [12:0] idx,
                                 input logic [7:0] byt, input logic [11:0] first);
        request_t r;
        r = '0;
        r.kind = kind;
        r.idx = idx;
        r.byt = byt;
        r.first = first;
        walk_step(r);
        pending_reqs.push_back(r);
        if (kind != REQ_UNUSED)
            requests_made++;
    endtask

    task automatic load_byte(input int pos, input logic [7:0] byt);
        queue_request(fccw_pkg::REQ_LOAD, pos[12:0], byt, 12'($urandom));
    endtask

    // A cluster's entry must be loaded before the walker reads it.
    task automatic need_entry(input int c);
        int pos;
        if (c >= 2)
        begin
            pos = c * 3 / 2;
            for (int k = 0; k < 2; k++)
                if (!fat_known[pos + k])
                    load_byte(pos + k, 8'($urandom));
        end
    endtask

    // Writes a 12-bit entry, keeping the nibble that belongs to the neighbor.
    task automatic set_fat_entry(input int c, input logic [11:0] v);
        int pos;
        logic [7:0] b0;
        logic [7:0] b1;
        pos = c * 3 / 2;
        b0 = fat_known[pos] ? fat_shadow[pos] : 8'($urandom);
        b1 = fat_known[pos + 1] ? fat_shadow[pos + 1] : 8'($urandom);
        if (c % 2 == 0)
        begin
            b0 = v[7:0];
            b1 = {b1[7:4], v[11:8]};
        end
        else
        begin
            b0 = {v[3:0], b0[3:0]};
            b1 = v[11:4];
        end
        load_byte(pos, b0);
        load_byte(pos + 1, b1);
    endtask

    task automatic start_chain(input int c);
        need_entry(c);
        queue_request(fccw_pkg::REQ_START, 13'($urandom), 8'($urandom), c[11:0]);
    endtask

    task automatic advance_chain();
        if (walk_active)
            need_entry(walk_cluster);
        queue_request(fccw_pkg::REQ_ADVANCE, 13'($urandom), 8'($urandom), 12'($urandom));
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == fccw_pkg::REG_DATA_START)
            lba_base = val;
        else
            spc_reg = val[7:0];
    endtask

    // Driver: holds a request until it is taken, then pulls the next one or idles.
    always @(negedge clk)
    begin
        if (rst_n && !(start && !req_taken))
        begin
            send = pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct;
            if (send)
            begin
                driven_req = pending_reqs.pop_front();
                start <= 1'b1;
                req_type <= driven_req.kind;
                fat_index <= driven_req.idx;
                fat_byte <= driven_req.byt;
                first_cluster <= driven_req.first;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: checks results against the oldest expectation and logs accepted requests.
    always @(posedge clk)
    begin
        request_t want;
        if (rst_n)
        begin
            if (result_strobe)
            begin
                if (expected_sectors.size() == 0)
                begin
                    $display("%0t: expected no result, actual lba=%h cnt=%h clus=%h last=%b bad=%b",
                             $time, sector_lba, sector_count, cluster_number,
                             last_cluster, bad_cluster);
                    mismatches++;
                end
                else
                begin
                    want = expected_sectors.pop_front();
                    if (sector_lba !== want.lba || sector_count !== want.cnt ||
                        cluster_number !== want.clus || last_cluster !== want.last ||
                        bad_cluster !== want.bad)
                    begin
                        $display("%0t: mismatch expected lba=%h cnt=%h clus=%h last=%b bad=%b",
                                 $time, want.lba, want.cnt, want.clus, want.last, want.bad);
                        $display("%0t:          actual lba=%h cnt=%h clus=%h last=%b bad=%b",
                                 $time, sector_lba, sector_count, cluster_number,
                                 last_cluster, bad_cluster);
                        mismatches++;
                    end
                end
            end
            req_taken = start && !busy;
            if (req_taken && driven_req.has_sector)
                expected_sectors.push_back(driven_req);
            if (req_taken || result_strobe)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int target;
        int r;
        int len;
        int n;
        int chain [8];
        target = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset configuration.
        load_byte(0, 8'h00);
        load_byte(FAT_SIZE - 1, 8'hFF);
        start_chain(0);
        start_chain(1);
        advance_chain();
        set_fat_entry(2, 12'd3);
        set_fat_entry(3, 12'hFFF);
        start_chain(2);
        advance_chain();
        advance_chain();
        // The top cluster is itself an end mark but is still reported and followed.
        set_fat_entry(4095, 12'd4094);
        set_fat_entry(4094, 12'hFF8);
        start_chain(4095);
        advance_chain();
        set_fat_entry(5, 12'd1);
        start_chain(5);
        advance_chain();
        queue_request(REQ_UNUSED, 13'($urandom), 8'($urandom), 12'($urandom));

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                1:
                begin
                    write_reg(fccw_pkg::REG_DATA_START, 16'hFFFF);
                    write_reg(fccw_pkg::REG_SPC, {8'($urandom), 8'd128});
                end
                2:
                begin
                    write_reg(fccw_pkg::REG_DATA_START, 16'($urandom));
                    write_reg(fccw_pkg::REG_SPC, {8'($urandom), 8'd255});
                end
                3:
                begin
                    write_reg(fccw_pkg::REG_DATA_START, 16'h0000);
                    write_reg(fccw_pkg::REG_SPC, {8'($urandom), 8'd0});
                end
                4:
                begin
                    write_reg(fccw_pkg::REG_DATA_START, 16'($urandom));
                    write_reg(fccw_pkg::REG_SPC, {8'($urandom), 8'($urandom_range(1, 128))});
                end
                5:
                begin
                    write_reg(fccw_pkg::REG_DATA_START, 16'($urandom));
                    write_reg(fccw_pkg::REG_SPC, {8'($urandom), 8'd1});
                end
                default: ;
            endcase
            idle_pct = (phase % 3 == 1) ? 68 : (phase % 3 == 2) ? 8 : 0;
            target += ITEMS_PER_PHASE;
            while (requests_made < target)
            begin
                r = $urandom_range(99);
                if (r < 70)
                begin
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                        chain[i] = $urandom_range(2, 4095);
                    for (int i = 0; i < len - 1; i++)
                        set_fat_entry(chain[i], 12'(chain[i + 1]));
                    n = len - 1;
                    if ($urandom_range(9) == 0)
                    begin
                        set_fat_entry(chain[len - 1], 12'($urandom_range(0, 1)));
                        n++;
                    end
                    else
                        set_fat_entry(chain[len - 1], 12'($urandom_range(12'hFF8, 12'hFFF)));
                    // Some walks are cut short by the next start.
                    if ($urandom_range(99) < 15)
                        n = $urandom_range(0, n);
                    n += $urandom_range(0, 1);
                    start_chain(chain[0]);
                    repeat (n) advance_chain();
                end
                else if (r < 82)
                    load_byte($urandom_range(0, FAT_SIZE - 1), 8'($urandom));
                else if (r < 90)
                    start_chain($urandom_range(0, 4095));
                else if (r < 97)
                    advance_chain();
                else
                    queue_request(REQ_UNUSED, 13'($urandom), 8'($urandom), 12'($urandom));
            end
            while (pending_reqs.size() != 0 || start || busy || expected_sectors.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end

        if (mismatches == 0 && expected_sectors.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[fat12_cluster_chain_walker_unit.f]
design/fccw_pkg.sv
design/fccw_ram.sv
design/fccw_ctrl.sv
design/fccw_datapath.sv
design/fat12_cluster_chain_walker_unit.sv
tb/sv/tb_fat12_cluster_chain_walker_unit.sv
